// File: rtl/kscl_pkg.sv
// Shared types, codes and defaults for the keyed slot cache.
package kscl_pkg;

    // Default sizing
    localparam int ENTRIES_DEF  = 48;
    localparam int KEY_BITS_DEF = 64;

    // Command codes
    localparam logic [1:0] CMD_DRAW  = 2'd0;
    localparam logic [1:0] CMD_DONE  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Entry state codes
    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_LOADING = 2'd1;
    localparam logic [1:0] ST_READY   = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    // Result status codes
    localparam logic [1:0] STS_LOADING = 2'd0;
    localparam logic [1:0] STS_READY   = 2'd1;
    localparam logic [1:0] STS_MISSING = 2'd2;
    localparam logic [1:0] STS_NONE    = 2'd3;

    // One command transfer
    typedef struct packed {
        logic [1:0]  cmd;
        logic        key_present;
        logic [63:0] key;
        logic        fetch_ok;
        logic [31:0] color_in;
    } t_in;

    // One result transfer
    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  entry_index;
        logic        fetch_request;
        logic [31:0] color_out;
    } t_out;

    // Running search record handed from cell to cell
    typedef struct packed {
        logic        hit;
        logic [1:0]  hit_state;
        logic [31:0] hit_color;
        logic        empty;
        logic        best;
        logic [31:0] best_stamp;
    } t_scan;

    // Write-back order broadcast to all cells
    typedef struct packed {
        logic       en;
        logic       set_key;
        logic       set_state;
        logic [1:0] state;
        logic       set_stamp;
        logic       set_color;
    } t_upd;

endpackage

// File: rtl/kscl_cell.sv
// One cache entry plus one stage of the search chain.
module kscl_cell #(
    parameter int ENTRIES  = kscl_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = kscl_pkg::KEY_BITS_DEF,
    parameter int IDX      = 0,
    localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [31:0]           i_color,
    input  logic [31:0]           i_stamp,
    input  logic                  i_tok,
    input  kscl_pkg::t_scan       i_scan,
    input  logic [IW-1:0]         i_hit_idx,
    input  logic [IW-1:0]         i_empty_idx,
    input  logic [IW-1:0]         i_best_idx,
    output logic                  o_tok,
    output kscl_pkg::t_scan       o_scan,
    output logic [IW-1:0]         o_hit_idx,
    output logic [IW-1:0]         o_empty_idx,
    output logic [IW-1:0]         o_best_idx,
    input  kscl_pkg::t_upd        i_upd,
    input  logic [IW-1:0]         i_upd_idx
);
    import kscl_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    // Entry contents
    logic [KEY_BITS-1:0] r_key;
    logic [1:0]          r_state;
    logic [31:0]         r_stamp;
    logic [31:0]         r_color;

    // Chain stage
    logic          r_tok;
    t_scan         r_scan;
    logic [IW-1:0] r_hit_idx;
    logic [IW-1:0] r_empty_idx;
    logic [IW-1:0] r_best_idx;

    t_scan         n_scan;
    logic [IW-1:0] n_hit_idx;
    logic [IW-1:0] n_empty_idx;
    logic [IW-1:0] n_best_idx;
    logic          upd_me;

    // Fold this entry into the running record
    always_comb begin
        n_scan      = i_scan;
        n_hit_idx   = i_hit_idx;
        n_empty_idx = i_empty_idx;
        n_best_idx  = i_best_idx;
        if (!i_scan.hit && r_state != ST_EMPTY && r_key == i_key) begin
            n_scan.hit       = 1'b1;
            n_scan.hit_state = r_state;
            n_scan.hit_color = r_color;
            n_hit_idx        = MY_IDX;
        end
        if (!i_scan.empty && r_state == ST_EMPTY) begin
            n_scan.empty = 1'b1;
            n_empty_idx  = MY_IDX;
        end
        if ((r_state == ST_READY || r_state == ST_MISSING)
            && (!i_scan.best || r_stamp < i_scan.best_stamp)) begin
            n_scan.best       = 1'b1;
            n_scan.best_stamp = r_stamp;
            n_best_idx        = MY_IDX;
        end
    end

    // Pass the token down the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    // Register the record
    always_ff @(posedge i_clk) begin
        r_scan      <= n_scan;
        r_hit_idx   <= n_hit_idx;
        r_empty_idx <= n_empty_idx;
        r_best_idx  <= n_best_idx;
    end

    assign upd_me = i_upd.en && (i_upd_idx == MY_IDX);

    // Apply write-back addressed to this entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
            r_stamp <= '0;
            r_color <= '0;
        end else if (upd_me) begin
            if (i_upd.set_state) begin
                r_state <= i_upd.state;
            end
            if (i_upd.set_stamp) begin
                r_stamp <= i_stamp;
            end
            if (i_upd.set_color) begin
                r_color <= i_color;
            end
        end
    end

    // Tag has no reset; it is read only once the entry leaves empty
    always_ff @(posedge i_clk) begin
        if (upd_me && i_upd.set_key) begin
            r_key <= i_key;
        end
    end

    assign o_tok       = r_tok;
    assign o_scan      = r_scan;
    assign o_hit_idx   = r_hit_idx;
    assign o_empty_idx = r_empty_idx;
    assign o_best_idx  = r_best_idx;

endmodule

// File: rtl/keyed_slot_cache_lru_claim.sv
// An accepted command is registered, searched cell by cell along the row, and its result registered.
// One command at a time: busy holds off new starts, and a new start is taken in the strobe cycle.
// The search token walks the row of entry cells one cell per cycle.
// Results are shown for one cycle on o_valid; the receiver cannot stall them.
// Synchronous active-low reset empties all entries, zeroes stamps, colors and the use clock.
// Top level: fully associative entry table with least-recently-used claiming.
module keyed_slot_cache_lru_claim #(
    parameter int ENTRIES  = kscl_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = kscl_pkg::KEY_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  kscl_pkg::t_in   i_data,
    output logic            o_valid,
    output kscl_pkg::t_out  o_result
);
    import kscl_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // Control
    logic        r_state;
    logic        r_go;
    logic [31:0] r_clock;
    logic        r_valid;

    // Held command
    logic [1:0]          r_cmd;
    logic                r_present;
    logic [KEY_BITS-1:0] r_key;
    logic                r_ok;
    logic [31:0]         r_color;
    t_out                r_result;

    // Chain wiring
    logic          tok       [0:ENTRIES];
    t_scan         scan      [0:ENTRIES];
    logic [IW-1:0] hit_idx   [0:ENTRIES];
    logic [IW-1:0] empty_idx [0:ENTRIES];
    logic [IW-1:0] best_idx  [0:ENTRIES];

    t_upd          upd;
    logic [IW-1:0] upd_idx;
    t_out          n_result;
    logic          accept;
    logic          done;
    t_scan         fin;

    assign accept = start && !busy;
    assign busy   = (r_state == S_SCAN);
    assign done   = tok[ENTRIES];
    assign fin    = scan[ENTRIES];

    // Seed the chain with an empty record
    assign tok[0]       = r_go;
    assign scan[0]      = '0;
    assign hit_idx[0]   = '0;
    assign empty_idx[0] = '0;
    assign best_idx[0]  = '0;

    // Row of entry cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kscl_cell #(
            .ENTRIES  (ENTRIES),
            .KEY_BITS (KEY_BITS),
            .IDX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_key),
            .i_color     (r_color),
            .i_stamp     (r_clock),
            .i_tok       (tok[g]),
            .i_scan      (scan[g]),
            .i_hit_idx   (hit_idx[g]),
            .i_empty_idx (empty_idx[g]),
            .i_best_idx  (best_idx[g]),
            .o_tok       (tok[g+1]),
            .o_scan      (scan[g+1]),
            .o_hit_idx   (hit_idx[g+1]),
            .o_empty_idx (empty_idx[g+1]),
            .o_best_idx  (best_idx[g+1]),
            .i_upd       (upd),
            .i_upd_idx   (upd_idx)
        );
    end

    // Decide the result and the write-back when the token leaves the row
    always_comb begin
        upd      = '0;
        upd_idx  = '0;
        n_result = '0;
        n_result.status = STS_NONE;
        case (r_cmd)
            CMD_DRAW: begin
                if (r_present && fin.hit) begin
                    upd.en        = done;
                    upd.set_stamp = 1'b1;
                    upd_idx       = hit_idx[ENTRIES];
                    n_result.status      = 2'(fin.hit_state - 2'd1);
                    n_result.entry_index = 6'(hit_idx[ENTRIES]);
                end else if (r_present && (fin.empty || fin.best)) begin
                    upd.en        = done;
                    upd.set_key   = 1'b1;
                    upd.set_state = 1'b1;
                    upd.state     = ST_LOADING;
                    upd.set_stamp = 1'b1;
                    upd_idx       = fin.empty ? empty_idx[ENTRIES] : best_idx[ENTRIES];
                    n_result.status        = STS_LOADING;
                    n_result.entry_index   = 6'(upd_idx);
                    n_result.fetch_request = 1'b1;
                end
            end
            CMD_DONE: begin
                if (r_present && fin.hit) begin
                    upd.en        = done;
                    upd.set_state = 1'b1;
                    upd.state     = r_ok ? ST_READY : ST_MISSING;
                    upd.set_color = r_ok;
                    upd_idx       = hit_idx[ENTRIES];
                    n_result.status      = r_ok ? STS_READY : STS_MISSING;
                    n_result.entry_index = 6'(hit_idx[ENTRIES]);
                end
            end
            CMD_QUERY: begin
                if (r_present && fin.hit) begin
                    n_result.status      = 2'(fin.hit_state - 2'd1);
                    n_result.entry_index = 6'(hit_idx[ENTRIES]);
                    n_result.color_out   = (fin.hit_state == ST_READY) ? fin.hit_color : '0;
                end
            end
            default: begin
                n_result.status = STS_NONE;
            end
        endcase
    end

    // Sequence the command: hold it while the token walks the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_clock <= '0;
            r_valid <= 1'b0;
        end else begin
            r_go    <= accept;
            r_valid <= done;
            if (accept) begin
                r_state <= S_SCAN;
                if (i_data.cmd == CMD_DRAW) begin
                    r_clock <= r_clock + 32'd1;
                end
            end else if (done) begin
                r_state <= S_IDLE;
            end
        end
    end

    // Capture the command payload and the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_data.cmd;
            r_present <= i_data.key_present;
            r_key     <= i_data.key[KEY_BITS-1:0];
            r_ok      <= i_data.fetch_ok;
            r_color   <= i_data.color_in;
        end
        if (done) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // A command ends exactly with its result strobe
    a_fall_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    // An accepted command keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not start a search");

    // Only one token travels the row at a time
    a_token_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |-> !done)
        else $error("search token overlap");

    // A fetch request always reports a claimed loading entry
    a_fetch_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.fetch_request |-> o_result.status == STS_LOADING)
        else $error("fetch request without loading status");

    // A color is returned only for a ready entry
    a_color_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.color_out != 32'd0 |-> o_result.status == STS_READY)
        else $error("color returned for an entry that is not ready");

endmodule

// File: tb/keyed_slot_cache_lru_claim_test.sv
// Self-checking testbench for the keyed slot cache with least-recently-used claiming.
module keyed_slot_cache_lru_claim_test;
    import kscl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          N_SLOTS    = ENTRIES_DEF;
    localparam int          TAG_BITS   = KEY_BITS_DEF;
    localparam logic [63:0] TAG_MASK   = {64{1'b1}} >> (64 - TAG_BITS);
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          RANDOM_CMDS = 726;
    localparam int          POOL_SIZE   = 64;
    localparam int          CYCLE_LIMIT = 500000;
    localparam logic [63:0] TAG_ZERO = 64'h0;
    localparam logic [63:0] TAG_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TAG_MIX  = 64'h5A5A_C3C3_0F0F_9669;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_data;
    logic o_valid;
    t_out o_result;

    keyed_slot_cache_lru_claim dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_data   (i_data),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the entry table
    logic [63:0] slot_tag   [N_SLOTS];
    logic [1:0]  slot_state [N_SLOTS];
    logic [31:0] slot_stamp [N_SLOTS];
    logic [31:0] slot_color [N_SLOTS];
    logic [31:0] use_count;

    t_out pending_outcomes [$];
    int   fail_count = 0;
    int   cycle_count = 0;
    int   burst_left = 0;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_dir_row;

    t_dir_row    dir_rows [$];
    logic [63:0] tag_pool [POOL_SIZE];

    function automatic logic [1:0] status_of(input logic [1:0] st);
        case (st)
            ST_LOADING: return STS_LOADING;
            ST_READY:   return STS_READY;
            ST_MISSING: return STS_MISSING;
            default:    return STS_NONE;
        endcase
    endfunction

    // Compute the result of one command and update the shadow table
    function automatic t_out slot_outcome(input t_in c);
        t_out        r;
        logic [63:0] k;
        int          hit;
        int          victim;
        int          i;
        r = '0;
        r.status = STS_NONE;
        k = c.key & TAG_MASK;
        hit = -1;
        victim = -1;
        if (c.key_present) begin
            for (i = 0; i < N_SLOTS; i++)
                if (hit < 0 && slot_state[i] != ST_EMPTY && slot_tag[i] == k)
                    hit = i;
        end
        case (c.cmd)
            CMD_DRAW: begin
                use_count = use_count + 32'd1;
                if (c.key_present && hit >= 0) begin
                    slot_stamp[hit] = use_count;
                    r.status = status_of(slot_state[hit]);
                    r.entry_index = 6'(hit);
                end else if (c.key_present) begin
                    // First empty entry wins, else oldest entry not loading
                    for (i = 0; i < N_SLOTS; i++) begin
                        if (victim < 0 || slot_state[victim] != ST_EMPTY) begin
                            if (slot_state[i] == ST_EMPTY)
                                victim = i;
                            else if (slot_state[i] != ST_LOADING &&
                                     (victim < 0 || slot_stamp[i] < slot_stamp[victim]))
                                victim = i;
                        end
                    end
                    if (victim >= 0) begin
                        slot_tag[victim]   = k;
                        slot_state[victim] = ST_LOADING;
                        slot_stamp[victim] = use_count;
                        r.status = STS_LOADING;
                        r.entry_index = 6'(victim);
                        r.fetch_request = 1'b1;
                    end
                end
            end
            CMD_DONE: begin
                if (hit >= 0) begin
                    if (c.fetch_ok) begin
                        slot_color[hit] = c.color_in;
                        slot_state[hit] = ST_READY;
                    end else begin
                        slot_state[hit] = ST_MISSING;
                    end
                    r.status = status_of(slot_state[hit]);
                    r.entry_index = 6'(hit);
                end
            end
            CMD_QUERY: begin
                if (hit >= 0) begin
                    r.status = status_of(slot_state[hit]);
                    r.entry_index = 6'(hit);
                    if (slot_state[hit] == ST_READY)
                        r.color_out = slot_color[hit];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    function automatic t_in make_cmd(input logic [1:0] cmd, input logic present,
                                     input logic [63:0] key, input logic ok,
                                     input logic [31:0] color);
        t_in c;
        c.cmd = cmd;
        c.key_present = present;
        c.key = key;
        c.fetch_ok = ok;
        c.color_in = color;
        return c;
    endfunction

    task automatic add_row(input t_in c, input bit typed, input logic [1:0] st,
                           input int idx, input logic fetch, input logic [31:0] color);
        t_dir_row row;
        row.item = c;
        row.typed = typed;
        row.want.status = st;
        row.want.entry_index = 6'(idx);
        row.want.fetch_request = fetch;
        row.want.color_out = color;
        dir_rows.push_back(row);
    endtask

    // Present one command in bursts with random gaps, hold until accepted
    task automatic issue(input t_in c, input bit typed, input t_out want);
        int   gap;
        t_out predicted;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, N_SLOTS + 4)
                                              : $urandom_range(0, 3);
        end
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_data <= c;
        do @(posedge i_clk); while (busy);
        burst_left--;
        predicted = slot_outcome(c);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic issue_checked(input t_in c);
        issue(c, 1'b0, '0);
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (pending_outcomes.size() == 0) begin
                flag_failure($sformatf("unexpected result: sts=%0d idx=%0d fetch=%0b color=%h",
                             o_result.status, o_result.entry_index,
                             o_result.fetch_request, o_result.color_out));
            end else begin
                want = pending_outcomes.pop_front();
                if (o_result.status !== want.status ||
                    o_result.entry_index !== want.entry_index ||
                    o_result.fetch_request !== want.fetch_request ||
                    o_result.color_out !== want.color_out)
                    flag_failure($sformatf(
                        "mismatch: exp sts=%0d idx=%0d fetch=%0b color=%h, got %s",
                        want.status, want.entry_index, want.fetch_request, want.color_out,
                        $sformatf("sts=%0d idx=%0d fetch=%0b color=%h",
                                  o_result.status, o_result.entry_index,
                                  o_result.fetch_request, o_result.color_out)));
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_in         c;
        int          n;
        int          r;
        int          i;
        logic [63:0] fresh [$];

        start   <= 1'b0;
        i_data  <= '0;
        i_rst_n <= 1'b0;
        for (i = 0; i < N_SLOTS; i++) begin
            slot_tag[i]   = '0;
            slot_state[i] = ST_EMPTY;
            slot_stamp[i] = '0;
            slot_color[i] = '0;
        end
        use_count = '0;

        // Directed rows: empty table, empty ids, unused code, state overwrites
        add_row(make_cmd(CMD_QUERY, 1'b1, TAG_ZERO, 1'b0, 0), 1'b1, STS_NONE, 0, 1'b0, 0);
        add_row(make_cmd(CMD_DRAW, 1'b0, TAG_ONES, 1'b1, 32'hFFFF_FFFF),
                1'b1, STS_NONE, 0, 1'b0, 0);
        add_row(make_cmd(CMD_UNUSED, 1'b0, TAG_ZERO, 1'b0, 0), 1'b1, STS_NONE, 0, 1'b0, 0);
        add_row(make_cmd(CMD_DONE, 1'b1, TAG_ZERO, 1'b1, 32'h1111_2222),
                1'b1, STS_NONE, 0, 1'b0, 0);
        add_row(make_cmd(CMD_DRAW, 1'b1, TAG_ZERO, 1'b0, 0), 1'b1, STS_LOADING, 0, 1'b1, 0);
        add_row(make_cmd(CMD_QUERY, 1'b1, TAG_ZERO, 1'b0, 0), 1'b1, STS_LOADING, 0, 1'b0, 0);
        add_row(make_cmd(CMD_DONE, 1'b1, TAG_ZERO, 1'b1, 32'hFFFF_FFFF),
                1'b1, STS_READY, 0, 1'b0, 0);
        add_row(make_cmd(CMD_QUERY, 1'b1, TAG_ZERO, 1'b0, 0),
                1'b1, STS_READY, 0, 1'b0, 32'hFFFF_FFFF);
        add_row(make_cmd(CMD_DRAW, 1'b1, TAG_ONES, 1'b0, 0), 1'b1, STS_LOADING, 1, 1'b1, 0);
        add_row(make_cmd(CMD_DONE, 1'b1, TAG_ONES, 1'b0, 32'h1234_5678),
                1'b1, STS_MISSING, 1, 1'b0, 0);
        add_row(make_cmd(CMD_QUERY, 1'b1, TAG_ONES, 1'b0, 0), 1'b1, STS_MISSING, 1, 1'b0, 0);
        add_row(make_cmd(CMD_DRAW, 1'b1, TAG_ONES, 1'b0, 0), 1'b1, STS_MISSING, 1, 1'b0, 0);
        add_row(make_cmd(CMD_DRAW, 1'b1, TAG_ZERO, 1'b0, 0), 1'b1, STS_READY, 0, 1'b0, 0);
        add_row(make_cmd(CMD_DONE, 1'b0, TAG_ZERO, 1'b1, 32'hDEAD_BEEF),
                1'b1, STS_NONE, 0, 1'b0, 0);
        add_row(make_cmd(CMD_QUERY, 1'b0, TAG_ZERO, 1'b0, 0), 1'b1, STS_NONE, 0, 1'b0, 0);
        add_row(make_cmd(CMD_DONE, 1'b1, TAG_ONES, 1'b1, 32'h0), 1'b1, STS_READY, 1, 1'b0, 0);
        add_row(make_cmd(CMD_DONE, 1'b1, TAG_ZERO, 1'b0, 32'hFFFF_FFFF),
                1'b1, STS_MISSING, 0, 1'b0, 0);
        add_row(make_cmd(CMD_QUERY, 1'b1, TAG_ZERO, 1'b0, 0), 1'b1, STS_MISSING, 0, 1'b0, 0);
        add_row(make_cmd(CMD_DONE, 1'b1, TAG_ZERO, 1'b1, 32'hA5A5_0F0F),
                1'b1, STS_READY, 0, 1'b0, 0);
        add_row(make_cmd(CMD_QUERY, 1'b1, TAG_ZERO, 1'b0, 0),
                1'b1, STS_READY, 0, 1'b0, 32'hA5A5_0F0F);
        add_row(make_cmd(CMD_UNUSED, 1'b1, TAG_ONES, 1'b1, 32'hFFFF_FFFF),
                1'b1, STS_NONE, 0, 1'b0, 0);
        add_row(make_cmd(CMD_DRAW, 1'b1, TAG_MIX, 1'b1, 32'h8000_0001),
                1'b1, STS_LOADING, 2, 1'b1, 0);
        add_row(make_cmd(CMD_DONE, 1'b1, TAG_MIX, 1'b1, 32'h8000_0001),
                1'b1, STS_READY, 2, 1'b0, 0);
        add_row(make_cmd(CMD_DRAW, 1'b1, TAG_ONES, 1'b0, 0), 1'b0, STS_NONE, 0, 1'b0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[j])
            issue(dir_rows[j].item, dir_rows[j].typed, dir_rows[j].want);

        // Claim every entry with fresh tags so the table fills with loading entries,
        // then miss twice more with nothing left to claim
        for (i = 0; i < N_SLOTS + 2; i++) begin
            fresh.push_back({$urandom, $urandom});
            issue_checked(make_cmd(CMD_DRAW, 1'b1, fresh[i], 1'b0, 0));
        end
        // Complete them in shuffled order
        fresh.shuffle();
        foreach (fresh[j])
            issue_checked(make_cmd(CMD_DONE, 1'b1, fresh[j], 1'($urandom), $urandom));

        // Random part: mostly tags from a pool a bit larger than the table
        for (i = 0; i < POOL_SIZE; i++)
            tag_pool[i] = {$urandom, $urandom};
        tag_pool[0] = TAG_ZERO;
        tag_pool[1] = TAG_ONES;
        n = 0;
        while (n < RANDOM_CMDS) begin
            r = $urandom_range(0, 99);
            c = make_cmd(CMD_DRAW, 1'b1, tag_pool[$urandom_range(0, POOL_SIZE - 1)],
                         1'($urandom), $urandom);
            if (r < 45)
                c.cmd = CMD_DRAW;
            else if (r < 70)
                c.cmd = CMD_DONE;
            else if (r < 88)
                c.cmd = CMD_QUERY;
            else if (r < 92)
                c.cmd = CMD_UNUSED;
            else if (r < 96) begin
                c.cmd = 2'($urandom_range(0, 2));
                c.key_present = 1'b0;
            end else begin
                c.cmd = 2'($urandom_range(0, 2));
                c.key = {$urandom, $urandom};
            end
            n++;
            issue_checked(c);
        end
        start <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (N_SLOTS + 8) @(posedge i_clk);

        if (pending_outcomes.size() != 0)
            flag_failure("results still outstanding at end of run");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
